@@ design/kbdsep_pkg.sv @@
// Package for the keyboard scancode event processor.
// Holds the item and result types, key codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kbdsep_pkg;

  localparam int KEY_COUNT  = 128;
  localparam int CODE_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [CODE_W-1:0] K_ENTER     = 7'd28;
  localparam logic [CODE_W-1:0] K_LCTRL     = 7'd29;
  localparam logic [CODE_W-1:0] K_C         = 7'd46;
  localparam logic [CODE_W-1:0] K_LALT      = 7'd56;
  localparam logic [CODE_W-1:0] K_F1        = 7'd59;
  localparam logic [CODE_W-1:0] K_KP7       = 7'd71;
  localparam logic [CODE_W-1:0] K_KP8       = 7'd72;
  localparam logic [CODE_W-1:0] K_KP9       = 7'd73;
  localparam logic [CODE_W-1:0] K_KP4       = 7'd75;
  localparam logic [CODE_W-1:0] K_KP6       = 7'd77;
  localparam logic [CODE_W-1:0] K_KP1       = 7'd79;
  localparam logic [CODE_W-1:0] K_KP2       = 7'd80;
  localparam logic [CODE_W-1:0] K_KP3       = 7'd81;
  localparam logic [CODE_W-1:0] K_KPENTER   = 7'd96;
  localparam logic [CODE_W-1:0] K_RCTRL     = 7'd97;
  localparam logic [CODE_W-1:0] K_RALT      = 7'd100;
  localparam logic [CODE_W-1:0] K_BLK_UP    = 7'd103;
  localparam logic [CODE_W-1:0] K_BLK_LEFT  = 7'd105;
  localparam logic [CODE_W-1:0] K_BLK_RIGHT = 7'd106;
  localparam logic [CODE_W-1:0] K_BLK_DOWN  = 7'd108;

  localparam int FKEY_COUNT = 10;

  typedef enum logic [1:0] {
    KIND_SCAN      = 2'd0,
    KIND_MAP_WRITE = 2'd1,
    KIND_QUERY     = 2'd2,
    KIND_CLEAR     = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRANSLATE_CURSOR   = 3'd0,
    REG_DIAG_KEYPAD        = 3'd1,
    REG_TRANSLATE_KP_ENTER = 3'd2,
    REG_IGNORE_CTRL_C      = 3'd3,
    REG_USE_KEYMAP         = 3'd4,
    REG_ACTIVE_CONSOLE     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        raw_byte;
    logic [CODE_W-1:0] table_index;
    logic [CODE_W-1:0] table_value;
    logic [CODE_W-1:0] query_key;
  } item_t;

  typedef struct packed {
    logic              event_valid;
    logic [CODE_W-1:0] event_key;
    logic              event_pressed;
    logic              interrupt_request;
    logic              console_switch;
    logic [3:0]        console_number;
    logic              query_pressed;
  } result_t;

endpackage

`default_nettype wire

@@ design/keyboard_scancode_event_processor_unit.sv @@
// Top level of the keyboard scancode event processor.
// Depends on kbdsep_pkg for types and key codes.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------
//   item     | item_valid/stall     | kbdsep_pkg::item_t
//   result   | result_valid/stall   | kbdsep_pkg::result_t
//   cfg      | cfg_valid/ready      | cfg_index, cfg_data
//
// One item is taken per cycle while item_stall is low; its result passes the stage and result registers.
// The keymap is read at the input transfer and its data is registered for the second stage.
// Reset is synchronous and restores the identity keymap and empty key state at once.
// A stalled result holds; the input keeps flowing until both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_scancode_event_processor_unit (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    item_valid,
  output logic                                         item_stall,
  input  wire kbdsep_pkg::item_t                       item,
  output logic                                         result_valid,
  input  wire logic                                    result_stall,
  output kbdsep_pkg::result_t                          result,
  input  wire logic                                    cfg_valid,
  output logic                                         cfg_ready,
  input  wire logic [kbdsep_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [kbdsep_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import kbdsep_pkg::*;

  logic                  translate_cursor;
  logic                  diag_keypad;
  logic                  translate_keypad_enter;
  logic                  ignore_ctrl_c;
  logic                  use_keymap;
  logic [5:0]            active_console;

  logic [CODE_W-1:0]     remap_mem [KEY_COUNT];
  logic [KEY_COUNT-1:0]  remap_written;
  logic [CODE_W-1:0]     remap_data;
  logic                  remap_hit;

  logic                  stage_valid;
  item_t                 stage;

  logic [KEY_COUNT-1:0]  key_map;
  logic [KEY_COUNT-1:0]  key_map_next;
  logic                  c_held;
  logic                  c_held_next;
  logic                  ctrl_held;
  logic                  ctrl_held_next;
  logic                  alt_held;
  logic                  alt_held_next;
  logic [FKEY_COUNT-1:0] fkeys_held;
  logic [FKEY_COUNT-1:0] fkeys_held_next;

  result_t               result_next;
  logic                  out_free;
  logic                  item_xfer;
  logic                  stage_xfer;

  logic [CODE_W-1:0]     code;
  logic [CODE_W-1:0]     rec_code;
  logic                  pressed;
  logic [3:0]            vt;
  logic                  do_switch;

  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = stage_valid && !out_free;
  assign item_xfer  = item_valid && !item_stall;
  assign stage_xfer = stage_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      translate_cursor       <= 1'b0;
      diag_keypad            <= 1'b0;
      translate_keypad_enter <= 1'b0;
      ignore_ctrl_c          <= 1'b0;
      use_keymap             <= 1'b0;
      active_console         <= 6'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TRANSLATE_CURSOR:   translate_cursor       <= cfg_data[0];
        REG_DIAG_KEYPAD:        diag_keypad            <= cfg_data[0];
        REG_TRANSLATE_KP_ENTER: translate_keypad_enter <= cfg_data[0];
        REG_IGNORE_CTRL_C:      ignore_ctrl_c          <= cfg_data[0];
        REG_USE_KEYMAP:         use_keymap             <= cfg_data[0];
        REG_ACTIVE_CONSOLE:     active_console         <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Keymap writes and reads both happen at the input transfer, so they stay in item order.
  always_ff @(posedge clk) begin
    if (item_xfer) begin
      remap_data <= remap_mem[item.raw_byte[CODE_W-1:0]];
      if (item.kind == KIND_MAP_WRITE) begin
        remap_mem[item.table_index] <= item.table_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remap_written <= '0;
    end else if (item_xfer && item.kind == KIND_MAP_WRITE) begin
      remap_written[item.table_index] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_xfer) begin
      stage     <= item;
      remap_hit <= remap_written[item.raw_byte[CODE_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_xfer) begin
      stage_valid <= 1'b1;
    end else if (stage_xfer) begin
      stage_valid <= 1'b0;
    end
  end

  always_comb begin
    key_map_next    = key_map;
    c_held_next     = c_held;
    ctrl_held_next  = ctrl_held;
    alt_held_next   = alt_held;
    fkeys_held_next = fkeys_held;
    result_next     = '0;
    pressed         = !stage.raw_byte[7];
    code            = stage.raw_byte[CODE_W-1:0];
    rec_code        = '0;
    vt              = '0;
    do_switch       = 1'b0;

    if (use_keymap && remap_hit) begin
      code = remap_data;
    end

    case (stage.kind)
      KIND_MAP_WRITE: ;
      KIND_QUERY: begin
        result_next.query_pressed = key_map[stage.query_key];
      end
      KIND_CLEAR: begin
        key_map_next    = '0;
        c_held_next     = 1'b0;
        ctrl_held_next  = 1'b0;
        alt_held_next   = 1'b0;
        fkeys_held_next = '0;
      end
      KIND_SCAN: begin
        if (code == K_C) begin
          c_held_next = pressed;
        end else if (code == K_LCTRL || code == K_RCTRL) begin
          ctrl_held_next = pressed;
        end else if (code == K_LALT || code == K_RALT) begin
          alt_held_next = pressed;
        end else begin
          for (int j = 0; j < FKEY_COUNT; j++) begin
            if (code == K_F1 + CODE_W'(j)) begin
              fkeys_held_next[j] = pressed;
            end
          end
        end

        result_next.interrupt_request = ctrl_held_next && c_held_next && !ignore_ctrl_c;

        for (int j = FKEY_COUNT - 1; j >= 0; j--) begin
          if (fkeys_held_next[j]) begin
            vt = 4'(j + 1);
          end
        end
        do_switch = alt_held_next && (|fkeys_held_next) && ({2'b00, vt} != active_console);

        if (do_switch) begin
          key_map_next               = '0;
          c_held_next                = 1'b0;
          ctrl_held_next             = 1'b0;
          alt_held_next              = 1'b0;
          fkeys_held_next            = '0;
          result_next.console_switch = 1'b1;
          result_next.console_number = vt;
        end else begin
          result_next.event_valid   = 1'b1;
          result_next.event_key     = code;
          result_next.event_pressed = pressed;

          rec_code = code;
          if (translate_cursor) begin
            if (rec_code == K_BLK_UP) begin
              rec_code = K_KP8;
            end else if (rec_code == K_BLK_LEFT) begin
              rec_code = K_KP4;
            end else if (rec_code == K_BLK_RIGHT) begin
              rec_code = K_KP6;
            end else if (rec_code == K_BLK_DOWN) begin
              rec_code = K_KP2;
            end
          end
          if (diag_keypad) begin
            if (rec_code == K_KP7) begin
              key_map_next[K_KP8] = pressed;
              key_map_next[K_KP4] = pressed;
            end else if (rec_code == K_KP9) begin
              key_map_next[K_KP8] = pressed;
              key_map_next[K_KP6] = pressed;
            end else if (rec_code == K_KP1) begin
              key_map_next[K_KP2] = pressed;
              key_map_next[K_KP4] = pressed;
            end else if (rec_code == K_KP3) begin
              key_map_next[K_KP2] = pressed;
              key_map_next[K_KP6] = pressed;
            end
          end
          if (translate_keypad_enter && rec_code == K_KPENTER) begin
            rec_code = K_ENTER;
          end
          key_map_next[rec_code] = pressed;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_map    <= '0;
      c_held     <= 1'b0;
      ctrl_held  <= 1'b0;
      alt_held   <= 1'b0;
      fkeys_held <= '0;
    end else if (stage_xfer) begin
      key_map    <= key_map_next;
      c_held     <= c_held_next;
      ctrl_held  <= ctrl_held_next;
      alt_held   <= alt_held_next;
      fkeys_held <= fkeys_held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_xfer) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_xfer) begin
      result_valid <= 1'b1;
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ design/kbdsep_checker.sv @@
// Port-level checker for the keyboard scancode event processor.
// Depends on kbdsep_pkg and is bound to keyboard_scancode_event_processor_unit.
`timescale 1ns / 1ps
`default_nettype none

module kbdsep_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                result_valid,
  input wire logic                result_stall,
  input wire kbdsep_pkg::result_t result
);
  import kbdsep_pkg::*;

  // A stalled result transfer must hold its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // A console switch replaces the key event.
  a_switch_no_event: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.console_switch |-> !result.event_valid)
    else $error("event delivered together with a console switch");

  a_switch_target: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.console_switch |->
      result.console_number != 4'd0 && result.console_number <= 4'd10)
    else $error("console switch target out of range");

  a_number_only_on_switch: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.console_number != 4'd0 |-> result.console_switch)
    else $error("console number without a switch");

endmodule

bind keyboard_scancode_event_processor_unit kbdsep_checker u_kbdsep_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for keyboard_scancode_event_processor_unit.
// A behavioral predictor tracks the key state and keymap; every result is checked against it or a directed row.
// Depends on kbdsep_pkg and the RTL of the top level.
`timescale 1ns / 1ps

module testbench;
  import kbdsep_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam result_t NO_RESULT = '0;
  localparam int PHASE_COUNT = 12;
  localparam int PHASE_ITEMS = 96;

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } vector_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [KEY_COUNT-1:0]  key_down_map;
  logic [CODE_W-1:0]     keymap [KEY_COUNT];
  logic                  c_down;
  logic                  ctrl_down;
  logic                  alt_down;
  logic [FKEY_COUNT-1:0] fn_down;
  logic                  tr_cursor;
  logic                  tr_diagonal;
  logic                  tr_kp_enter;
  logic                  no_interrupt;
  logic                  keymap_on;
  logic [5:0]            console;

  result_t expected_results [$];
  vector_t directed_vectors [$];
  int      mismatch_count = 0;
  bit      idle_on = 1'b1;
  int      stall_left = 0;

  keyboard_scancode_event_processor_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic void clear_held_keys();
    key_down_map = '0;
    c_down = 1'b0;
    ctrl_down = 1'b0;
    alt_down = 1'b0;
    fn_down = '0;
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t           r;
    logic [CODE_W-1:0] code;
    logic              pressed;
    logic [3:0]        vt;
    r = '0;
    case (it.kind)
      KIND_MAP_WRITE: keymap[it.table_index] = it.table_value;
      KIND_QUERY: r.query_pressed = key_down_map[it.query_key];
      KIND_CLEAR: clear_held_keys();
      default: begin
        code = it.raw_byte[6:0];
        pressed = !it.raw_byte[7];
        if (keymap_on) code = keymap[code];
        if (code == K_C) c_down = pressed;
        else if (code == K_LCTRL || code == K_RCTRL) ctrl_down = pressed;
        else if (code == K_LALT || code == K_RALT) alt_down = pressed;
        else if (code >= K_F1 && code < K_F1 + FKEY_COUNT) fn_down[code - K_F1] = pressed;
        r.interrupt_request = ctrl_down && c_down && !no_interrupt;
        vt = '0;
        if (alt_down) begin
          for (int i = FKEY_COUNT - 1; i >= 0; i--) begin
            if (fn_down[i]) vt = 4'(i + 1);
          end
        end
        if (vt != 0 && {2'b00, vt} != console) begin
          clear_held_keys();
          r.console_switch = 1'b1;
          r.console_number = vt;
        end else begin
          r.event_valid = 1'b1;
          r.event_key = code;
          r.event_pressed = pressed;
          if (tr_cursor) begin
            case (code)
              K_BLK_UP:    code = K_KP8;
              K_BLK_LEFT:  code = K_KP4;
              K_BLK_RIGHT: code = K_KP6;
              K_BLK_DOWN:  code = K_KP2;
              default: ;
            endcase
          end
          if (tr_diagonal) begin
            case (code)
              K_KP7: begin
                key_down_map[K_KP8] = pressed;
                key_down_map[K_KP4] = pressed;
              end
              K_KP9: begin
                key_down_map[K_KP8] = pressed;
                key_down_map[K_KP6] = pressed;
              end
              K_KP1: begin
                key_down_map[K_KP2] = pressed;
                key_down_map[K_KP4] = pressed;
              end
              K_KP3: begin
                key_down_map[K_KP2] = pressed;
                key_down_map[K_KP6] = pressed;
              end
              default: ;
            endcase
          end
          if (tr_kp_enter && code == K_KPENTER) code = K_ENTER;
          key_down_map[code] = pressed;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] hot_code();
    logic [CODE_W-1:0] code;
    case ($urandom_range(0, 23))
      0:  code = K_LCTRL;
      1:  code = K_RCTRL;
      2:  code = K_C;
      3:  code = K_LALT;
      4:  code = K_RALT;
      5:  code = 7'(K_F1 + $urandom_range(0, FKEY_COUNT - 1));
      6:  code = K_KP7;
      7:  code = K_KP9;
      8:  code = K_KP1;
      9:  code = K_KP3;
      10: code = K_KPENTER;
      11: code = K_BLK_UP;
      12: code = K_BLK_LEFT;
      13: code = K_BLK_RIGHT;
      14: code = K_BLK_DOWN;
      15: code = K_ENTER;
      16: code = K_KP8;
      17: code = K_KP4;
      18: code = K_KP6;
      19: code = K_KP2;
      default: code = 7'($urandom_range(0, KEY_COUNT - 1));
    endcase
    return code;
  endfunction

  function automatic item_t rand_item();
    item_t       it;
    logic [31:0] bits;
    int          sel;
    bits = $urandom;
    it = bits[$bits(item_t)-1:0];
    sel = $urandom_range(0, 19);
    if (sel < 14) begin
      it.kind = KIND_SCAN;
      if ($urandom_range(0, 1)) it.raw_byte[6:0] = hot_code();
      it.raw_byte[7] = ($urandom_range(0, 4) < 2);
    end else if (sel < 16) begin
      it.kind = KIND_MAP_WRITE;
      if ($urandom_range(0, 1)) it.table_index = hot_code();
      if ($urandom_range(0, 1)) it.table_value = hot_code();
    end else if (sel < 19) begin
      it.kind = KIND_QUERY;
      if ($urandom_range(0, 3) != 0) it.query_key = hot_code();
    end else begin
      it.kind = KIND_CLEAR;
    end
    return it;
  endfunction

  task automatic add_row(item_t stim, bit typed, result_t want);
    directed_vectors.push_back('{stim: stim, typed: typed, want: want});
  endtask

  task automatic send_item(item_t stim, bit typed, result_t want);
    result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= stim;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = predict_result(stim);
    expected_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TRANSLATE_CURSOR:   tr_cursor = data[0];
      REG_DIAG_KEYPAD:        tr_diagonal = data[0];
      REG_TRANSLATE_KP_ENTER: tr_kp_enter = data[0];
      REG_IGNORE_CTRL_C:      no_interrupt = data[0];
      REG_USE_KEYMAP:         keymap_on = data[0];
      REG_ACTIVE_CONSOLE:     console = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst || !idle_on) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("event_valid", 8'(result.event_valid), 8'(want.event_valid));
        check_field("event_key", 8'(result.event_key), 8'(want.event_key));
        check_field("event_pressed", 8'(result.event_pressed), 8'(want.event_pressed));
        check_field("interrupt_request", 8'(result.interrupt_request),
                    8'(want.interrupt_request));
        check_field("console_switch", 8'(result.console_switch), 8'(want.console_switch));
        check_field("console_number", 8'(result.console_number), 8'(want.console_number));
        check_field("query_pressed", 8'(result.query_pressed), 8'(want.query_pressed));
      end
    end
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] flag_data;
    tr_cursor = 1'b0;
    tr_diagonal = 1'b0;
    tr_kp_enter = 1'b0;
    no_interrupt = 1'b0;
    keymap_on = 1'b0;
    console = 6'd1;
    for (int i = 0; i < KEY_COUNT; i++) keymap[i] = 7'(i);
    clear_held_keys();

    add_row(item_t'{KIND_QUERY, 8'hff, 7'h7f, 7'h7f, 7'd0}, 1'b1, NO_RESULT);
    add_row(item_t'{KIND_SCAN, 8'h00, 7'h7f, 7'h7f, 7'h7f}, 1'b1,
            result_t'{1'b1, 7'd0, 1'b1, 1'b0, 1'b0, 4'd0, 1'b0});
    add_row(item_t'{KIND_SCAN, 8'hff, 7'h7f, 7'h7f, 7'h7f}, 1'b1,
            result_t'{1'b1, 7'h7f, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0});
    add_row(item_t'{KIND_QUERY, 8'h00, 7'h00, 7'h00, 7'd0}, 1'b1,
            result_t'{1'b0, 7'd0, 1'b0, 1'b0, 1'b0, 4'd0, 1'b1});
    add_row(item_t'{KIND_QUERY, 8'h00, 7'h00, 7'h00, 7'h7f}, 1'b1, NO_RESULT);
    add_row(item_t'{KIND_MAP_WRITE, 8'hff, 7'h7f, 7'h00, 7'h7f}, 1'b1, NO_RESULT);
    add_row(item_t'{KIND_MAP_WRITE, 8'hff, 7'h00, 7'h7f, 7'h7f}, 1'b1, NO_RESULT);
    add_row(item_t'{KIND_SCAN, {1'b0, K_LCTRL}, 7'd0, 7'd0, 7'd0}, 1'b0, NO_RESULT);
    add_row(item_t'{KIND_SCAN, {1'b0, K_C}, 7'd0, 7'd0, 7'd0}, 1'b0, NO_RESULT);
    add_row(item_t'{KIND_SCAN, {1'b1, K_C}, 7'd0, 7'd0, 7'd0}, 1'b0, NO_RESULT);
    add_row(item_t'{KIND_SCAN, {1'b0, K_LALT}, 7'd0, 7'd0, 7'd0}, 1'b0, NO_RESULT);
    add_row(item_t'{KIND_SCAN, {1'b0, K_F1}, 7'd0, 7'd0, 7'd0}, 1'b0, NO_RESULT);
    add_row(item_t'{KIND_SCAN, {1'b0, 7'(K_F1 + 1)}, 7'd0, 7'd0, 7'd0}, 1'b0, NO_RESULT);
    add_row(item_t'{KIND_SCAN, {1'b1, K_F1}, 7'd0, 7'd0, 7'd0}, 1'b0, NO_RESULT);
    add_row(item_t'{KIND_QUERY, 8'h00, 7'd0, 7'd0, K_LALT}, 1'b0, NO_RESULT);
    add_row(item_t'{KIND_SCAN, {1'b0, K_RALT}, 7'd0, 7'd0, 7'd0}, 1'b0, NO_RESULT);
    add_row(item_t'{KIND_SCAN, {1'b0, 7'(K_F1 + FKEY_COUNT - 1)}, 7'd0, 7'd0, 7'd0},
            1'b0, NO_RESULT);
    add_row(item_t'{KIND_SCAN, {1'b0, K_KP7}, 7'd0, 7'd0, 7'd0}, 1'b0, NO_RESULT);
    add_row(item_t'{KIND_SCAN, {1'b0, K_BLK_UP}, 7'd0, 7'd0, 7'd0}, 1'b0, NO_RESULT);
    add_row(item_t'{KIND_SCAN, {1'b0, K_KPENTER}, 7'd0, 7'd0, 7'd0}, 1'b0, NO_RESULT);
    add_row(item_t'{KIND_CLEAR, 8'hff, 7'h7f, 7'h7f, 7'h7f}, 1'b1, NO_RESULT);
    add_row(item_t'{KIND_QUERY, 8'h00, 7'd0, 7'd0, K_KPENTER}, 1'b1, NO_RESULT);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_vectors[i]) begin
      send_item(directed_vectors[i].stim, directed_vectors[i].typed,
                directed_vectors[i].want);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      item_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clk);
      idle_on = (p % 4 != 2) && (p < PHASE_COUNT - 2);
      for (int r = REG_TRANSLATE_CURSOR; r <= REG_USE_KEYMAP; r++) begin
        flag_data = (p == 0) ? '0 : (p == 1) ? '1 : CFG_DATA_W'($urandom);
        write_reg(CFG_IDX_W'(r), flag_data);
      end
      if (p == 0) write_reg(REG_ACTIVE_CONSOLE, '0);
      else if (p == 1) write_reg(REG_ACTIVE_CONSOLE, '1);
      else if ($urandom_range(0, 3) == 0) write_reg(REG_ACTIVE_CONSOLE, CFG_DATA_W'($urandom));
      else write_reg(REG_ACTIVE_CONSOLE, CFG_DATA_W'($urandom_range(1, FKEY_COUNT)));
      write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LO : REG_SPARE_HI,
                CFG_DATA_W'($urandom));
      cfg_valid <= 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_item(), 1'b0, NO_RESULT);
    end

    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/kbdsep_pkg.sv
design/keyboard_scancode_event_processor_unit.sv
design/kbdsep_checker.sv
tb/sv/testbench.sv
